FILE: sv/dtsd_pkg.sv
package dtsd_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [6:0] ScoreMax   = 7'd99;
   localparam logic [6:0] ShownReset = 7'd127;
   localparam logic [7:0] ThreshReset = 8'd10;

   localparam logic [1:0] DigitAwayOnes = 2'd0;
   localparam logic [1:0] DigitAwayTens = 2'd1;
   localparam logic [1:0] DigitHomeOnes = 2'd2;
   localparam logic [1:0] DigitHomeTens = 2'd3;

   typedef struct packed {
      logic [6:0] away;
      logic [6:0] home;
   } frame_type;

   typedef struct packed {
      logic [1:0] count;
      frame_type  first;
      frame_type  second;
   } push_type;

   function automatic logic [6:0] score_step(input logic [6:0] s, input logic up);
      logic [6:0] v;
      v = (s > ScoreMax) ? 7'd0 : s;
      if (up) begin
         return (v >= ScoreMax) ? 7'd0 : v + 7'd1;
      end
      return (v == 7'd0) ? ScoreMax : v - 7'd1;
   endfunction

   // tens = floor(s / 10) by reciprocal, exact for 0..127
   function automatic logic [3:0] tens_of(input logic [6:0] s);
      logic [14:0] p;
      p = {8'd0, s} * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] ones_of(input logic [6:0] s);
      logic [6:0] t;
      t = {3'd0, tens_of(s)} * 7'd10;
      return 4'(s - t);
   endfunction

   function automatic logic [7:0] seg_of(input logic [3:0] d);
      logic [7:0] r;
      unique case (d)
         4'd0: r = 8'h7E;
         4'd1: r = 8'h30;
         4'd2: r = 8'h6D;
         4'd3: r = 8'h79;
         4'd4: r = 8'h33;
         4'd5: r = 8'h5B;
         4'd6: r = 8'h5F;
         4'd7: r = 8'h70;
         4'd8: r = 8'h7F;
         4'd9: r = 8'h7B;
         default: r = 8'h7E;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/dtsd_front.sv
module dtsd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_valid,
   input  logic                  home_button,
   input  logic                  away_button,
   input  logic                  count_up,
   input  logic [7:0]            threshold,
   output dtsd_pkg::push_type    push
);

   logic [6:0] home_score_ff, home_score_in;
   logic [6:0] away_score_ff, away_score_in;
   logic [6:0] shown_home_ff, shown_home_in;
   logic [6:0] shown_away_ff, shown_away_in;
   logic [7:0] home_cnt_ff, home_cnt_in;
   logic [7:0] away_cnt_ff, away_cnt_in;
   logic       home_lat_ff, home_lat_in;
   logic       away_lat_ff, away_lat_in;

   logic       clear, change;
   logic [6:0] hs, as, sh, sa;
   logic [7:0] home_inc, away_inc;
   logic       home_dis, away_dis, home_flip, away_flip;

   always_comb begin
      clear = home_button & away_button;
      hs = clear ? 7'd0 : home_score_ff;
      as = clear ? 7'd0 : away_score_ff;
      sh = clear ? 7'd0 : shown_home_ff;
      sa = clear ? 7'd0 : shown_away_ff;

      home_dis  = home_button != home_lat_ff;
      home_inc  = home_cnt_ff + 8'd1;
      home_flip = home_dis && (home_inc >= threshold);
      home_cnt_in = home_dis ? (home_flip ? 8'd0 : home_inc) : home_cnt_ff;
      home_lat_in = home_flip ? home_button : home_lat_ff;
      home_score_in = (home_flip && home_button) ? dtsd_pkg::score_step(hs, count_up) : hs;

      away_dis  = away_button != away_lat_ff;
      away_inc  = away_cnt_ff + 8'd1;
      away_flip = away_dis && (away_inc >= threshold);
      away_cnt_in = away_dis ? (away_flip ? 8'd0 : away_inc) : away_cnt_ff;
      away_lat_in = away_flip ? away_button : away_lat_ff;
      away_score_in = (away_flip && away_button) ? dtsd_pkg::score_step(as, count_up) : as;

      change = (home_score_in != sh) || (away_score_in != sa);
      shown_home_in = change ? home_score_in : sh;
      shown_away_in = change ? away_score_in : sa;

      push.count       = 2'd0;
      push.first.away  = away_score_in;
      push.first.home  = home_score_in;
      push.second.away = away_score_in;
      push.second.home = home_score_in;
      if (tick_valid) begin
         push.count = {1'b0, clear} + {1'b0, change};
         if (clear) begin
            push.first.away = 7'd0;
            push.first.home = 7'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_score_ff <= 7'd0;
         away_score_ff <= 7'd0;
         shown_home_ff <= dtsd_pkg::ShownReset;
         shown_away_ff <= dtsd_pkg::ShownReset;
         home_cnt_ff   <= 8'd0;
         away_cnt_ff   <= 8'd0;
         home_lat_ff   <= 1'b0;
         away_lat_ff   <= 1'b0;
      end else if (tick_valid) begin
         home_score_ff <= home_score_in;
         away_score_ff <= away_score_in;
         shown_home_ff <= shown_home_in;
         shown_away_ff <= shown_away_in;
         home_cnt_ff   <= home_cnt_in;
         away_cnt_ff   <= away_cnt_in;
         home_lat_ff   <= home_lat_in;
         away_lat_ff   <= away_lat_in;
      end
   end

endmodule

FILE: sv/dtsd_queue.sv
module dtsd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dtsd_pkg::push_type    push,
   input  logic                  pop,
   output logic                  has_room,
   output logic                  not_empty,
   output dtsd_pkg::frame_type   head
);

   localparam int unsigned PtrW = dtsd_pkg::QueuePtrW;
   localparam int unsigned CntW = dtsd_pkg::QueueCntW;

   dtsd_pkg::frame_type mem_ff [dtsd_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [PtrW-1:0] wr_next;
   logic            do_pop;

   always_comb begin
      not_empty = cnt_ff != '0;
      has_room  = cnt_ff <= CntW'(dtsd_pkg::QueueDepth - 2);
      head      = mem_ff[rd_ptr_ff];
      do_pop    = pop && not_empty;
      wr_next   = wr_ptr_ff + PtrW'(1);
      wr_ptr_in = wr_ptr_ff + PtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrW'(do_pop);
      cnt_in    = cnt_ff + CntW'(push.count) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/dtsd_back.sv
module dtsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  not_empty,
   input  dtsd_pkg::frame_type   head,
   output logic                  pop,
   output logic                  out_valid,
   output logic [7:0]            out_data,
   output logic                  out_last,
   input  logic                  out_ready
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;
   logic [3:0] digit;

   always_comb begin
      load = !valid_ff || out_ready;
      unique case (idx_ff)
         dtsd_pkg::DigitAwayOnes: digit = dtsd_pkg::ones_of(head.away);
         dtsd_pkg::DigitAwayTens: digit = dtsd_pkg::tens_of(head.away);
         dtsd_pkg::DigitHomeOnes: digit = dtsd_pkg::ones_of(head.home);
         dtsd_pkg::DigitHomeTens: digit = dtsd_pkg::tens_of(head.home);
         default:                 digit = 4'd0;
      endcase
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = not_empty;
         if (not_empty) begin
            data_in = dtsd_pkg::seg_of(digit);
            last_in = idx_ff == dtsd_pkg::DigitHomeTens;
            idx_in  = idx_ff + 2'd1;
            pop     = idx_ff == dtsd_pkg::DigitHomeTens;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= dtsd_pkg::DigitAwayOnes;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

FILE: sv/debounced_two_score_display_core.sv
// Debounced two-score display. Each req word is one sample tick of the home and away
// buttons and the up/down switch; it is taken whenever the frame queue has room for
// two frames. A tick yields zero, four or eight segment bytes (clear frame and change
// frame), away ones, away tens, home ones, home tens, the last with tlast set.
// The byte serializer sends one byte per cycle while rsp_tready is held high, and
// holds its byte while rsp_tready is low; the four-frame queue lets ticks arrive back
// to back while bytes drain. Debounce threshold is CSR offset 0 (reset 10).
module debounced_two_score_display_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] home_button, [1] away_button, [2] count_up

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] segment_byte
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]          thresh_ff;
   logic                tick;
   logic                has_room, not_empty, pop;
   dtsd_pkg::push_type  push;
   dtsd_pkg::frame_type head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {24'd0, thresh_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= dtsd_pkg::ThreshReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         thresh_ff <= csr_pwdata[7:0];
      end
   end

   assign req_tready = has_room;
   assign tick       = req_tvalid && has_room;

   dtsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .tick_valid  (tick),
      .home_button (req_tdata[0]),
      .away_button (req_tdata[1]),
      .count_up    (req_tdata[2]),
      .threshold   (thresh_ff),
      .push        (push)
   );

   dtsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .has_room  (has_room),
      .not_empty (not_empty),
      .head      (head)
   );

   dtsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule
